@@ design/mcm_pkg.sv @@
// shared types and constants of the 4x4 chained matrix multiplier
package mcm_pkg;

    // fixed point format of all matrix elements
    localparam int FRAC_BITS = 16;
    localparam int DIM       = 4;
    localparam int ELEM_W    = 32;
    localparam int COL_W     = 2;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = PROD_W + 2;

    // one in the fixed point format, used for the identity diagonal
    localparam logic [ELEM_W-1:0] FIX_ONE = ELEM_W'(1) << FRAC_BITS;

    // last column of a pass, commits the pending matrix
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(DIM - 1);

    typedef enum logic
    {
        CMD_LOAD     = 1'b0,
        CMD_MULTIPLY = 1'b1
    } command_t;

    typedef logic [DIM-1:0][ELEM_W-1:0] vec_t;

    typedef struct packed
    {
        command_t                 command;
        logic [COL_W-1:0]         column;
        logic signed [ELEM_W-1:0] elem0;
        logic signed [ELEM_W-1:0] elem1;
        logic signed [ELEM_W-1:0] elem2;
        logic signed [ELEM_W-1:0] elem3;
    } item_t;

    typedef struct packed
    {
        logic signed [ELEM_W-1:0] prod0;
        logic signed [ELEM_W-1:0] prod1;
        logic signed [ELEM_W-1:0] prod2;
        logic signed [ELEM_W-1:0] prod3;
        logic [COL_W-1:0]         out_column;
        logic                     last;
    } result_t;

endpackage

@@ design/mcm_dot_row.sv @@
// one row of the matrix times a column: exact dot product, floor shift, saturation
module mcm_dot_row
(
    input  mcm_pkg::vec_t                      row_elems,
    input  mcm_pkg::vec_t                      col_elems,
    output logic signed [mcm_pkg::ELEM_W-1:0]  dot
);

    logic signed [mcm_pkg::PROD_W-1:0] prod [mcm_pkg::DIM];
    logic signed [mcm_pkg::SUM_W-1:0]  sum;
    logic signed [mcm_pkg::SUM_W-1:0]  shifted;
    logic                              all_ones;
    logic                              all_zeros;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < mcm_pkg::DIM; k++)
        begin
            prod[k] = $signed(row_elems[k]) * $signed(col_elems[k]);
            sum     = sum + mcm_pkg::SUM_W'(prod[k]);
        end
        // arithmetic shift rounds toward minus infinity
        shifted   = sum >>> mcm_pkg::FRAC_BITS;
        all_ones  = &shifted[mcm_pkg::SUM_W-1:mcm_pkg::ELEM_W-1];
        all_zeros = ~|shifted[mcm_pkg::SUM_W-1:mcm_pkg::ELEM_W-1];
        if (shifted[mcm_pkg::SUM_W-1] && !all_ones)
        begin
            dot = {1'b1, {(mcm_pkg::ELEM_W-1){1'b0}}};
        end
        else if (!shifted[mcm_pkg::SUM_W-1] && !all_zeros)
        begin
            dot = {1'b0, {(mcm_pkg::ELEM_W-1){1'b1}}};
        end
        else
        begin
            dot = shifted[mcm_pkg::ELEM_W-1:0];
        end
    end

endmodule

@@ design/matrix4x4_chain_multiply_core.sv @@
// top level of the 4x4 chained matrix multiplier
// a multiply transaction passes the input register, then the result register
// throughput: one transaction per cycle, loads and multiplies alike, unless a
//   multiply waits on a full result register; single pass of 16 parallel multipliers
// a load transaction updates the accumulated matrix and gives no result
// reset: asynchronous, active low; accumulated matrix becomes identity,
//   pending matrix becomes zero, both pipeline slots empty
module matrix4x4_chain_multiply_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mcm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output mcm_pkg::result_t result
);

    localparam int NUM_ELEMS = mcm_pkg::DIM * mcm_pkg::DIM;

    // input stage
    logic           in_valid_reg;
    logic           in_valid_next;
    mcm_pkg::item_t in_reg;

    // result stage
    logic             out_valid_reg;
    logic             out_valid_next;
    mcm_pkg::result_t out_reg;
    mcm_pkg::result_t out_next;

    // matrix state, column major: row r of column c at 4*c + r
    logic [mcm_pkg::ELEM_W-1:0] accum_reg   [NUM_ELEMS];
    logic [mcm_pkg::ELEM_W-1:0] accum_next  [NUM_ELEMS];
    logic [mcm_pkg::ELEM_W-1:0] pending_reg [NUM_ELEMS];
    logic [mcm_pkg::ELEM_W-1:0] pending_next[NUM_ELEMS];

    logic                              is_multiply;
    logic                              advance;
    logic                              item_accept;
    mcm_pkg::vec_t                     col_vec;
    mcm_pkg::vec_t                     row_vec [mcm_pkg::DIM];
    logic signed [mcm_pkg::ELEM_W-1:0] dot     [mcm_pkg::DIM];

    // a load needs no result slot, a multiply waits for the result register
    assign is_multiply = (in_reg.command == mcm_pkg::CMD_MULTIPLY);
    assign advance     = in_valid_reg && (!is_multiply || !out_valid_reg || result_ready);
    assign item_ready  = !in_valid_reg || advance;
    assign item_accept = item_valid && item_ready;

    assign col_vec = {in_reg.elem3, in_reg.elem2, in_reg.elem1, in_reg.elem0};

    // sixteen multipliers, one row unit per output row
    for (genvar r = 0; r < mcm_pkg::DIM; r++)
    begin : g_row
        for (genvar k = 0; k < mcm_pkg::DIM; k++)
        begin : g_tap
            assign row_vec[r][k] = accum_reg[mcm_pkg::DIM * k + r];
        end

        mcm_dot_row u_dot_row
        (
            .row_elems (row_vec[r]),
            .col_elems (col_vec),
            .dot       (dot[r])
        );
    end

    always_comb
    begin
        in_valid_next = item_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

        // result register drains on handshake, refills on an advancing multiply
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        accum_next     = accum_reg;
        pending_next   = pending_reg;

        if (advance)
        begin
            if (is_multiply)
            begin
                out_valid_next      = 1'b1;
                out_next.prod0      = dot[0];
                out_next.prod1      = dot[1];
                out_next.prod2      = dot[2];
                out_next.prod3      = dot[3];
                out_next.out_column = in_reg.column;
                out_next.last       = (in_reg.column == mcm_pkg::LAST_COL);
                for (int r = 0; r < mcm_pkg::DIM; r++)
                begin
                    pending_next[{in_reg.column, 2'(r)}] = dot[r];
                end
                // commit the pass, including the column just computed
                if (in_reg.column == mcm_pkg::LAST_COL)
                begin
                    accum_next = pending_next;
                end
            end
            else
            begin
                for (int r = 0; r < mcm_pkg::DIM; r++)
                begin
                    accum_next[{in_reg.column, 2'(r)}] = col_vec[r];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            // identity on the diagonal, pending matrix cleared
            for (int c = 0; c < mcm_pkg::DIM; c++)
            begin
                for (int r = 0; r < mcm_pkg::DIM; r++)
                begin
                    accum_reg[{2'(c), 2'(r)}]   <= (c == r) ? mcm_pkg::FIX_ONE : '0;
                    pending_reg[{2'(c), 2'(r)}] <= '0;
                end
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            accum_reg     <= accum_next;
            pending_reg   <= pending_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            in_reg <= item;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ design/mcm_checker.sv @@
// port level checker of the 4x4 chained matrix multiplier, bound to the top level
module mcm_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input mcm_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input mcm_pkg::result_t result
);

    // a waiting result transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // a waiting result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // last marks exactly the final column of a pass
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (result.out_column == mcm_pkg::LAST_COL)))
        else $error("last flag does not match column");

    // with the result slot empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result slot");

endmodule

bind matrix4x4_chain_multiply_core mcm_checker u_mcm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

@@ tb/tb_top.sv @@
// self-checking testbench of the 4x4 chained matrix multiplier
module tb_top;
    import mcm_pkg::*;

    // number of input transactions to send, directed part included
    localparam int ITEMS     = 500;
    // cycles to watch for stray results once nothing is expected
    localparam int END_WAIT  = 8;
    // length of the long receiver hold-off that fills the pipeline
    localparam int HOLD_LEN  = 300;
    localparam int LIMIT     = 200000;
    // small random elements stay within +-4.0 so most products do not saturate
    localparam int SMALL_SPAN = 4 << FRAC_BITS;

    localparam logic signed [ELEM_W-1:0] MAX_Q = 32'h7FFFFFFF;
    localparam logic signed [ELEM_W-1:0] MIN_Q = 32'h80000000;

    // one transaction of stimulus; known marks a result typed in by hand
    typedef struct packed
    {
        item_t   it;
        logic    known;
        result_t res;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // traffic shaping: quiet turns off all idling, hold_go starts the long hold-off
    logic quiet;
    logic hold_go;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    int sent_cnt  = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    stim_row_t dir_tab[$];
    // per sent transaction, in order, the hand-typed result if there is one
    stim_row_t row_q[$];
    // product columns still to come out of the block
    result_t   product_q[$];

    // shadow copies of the accumulated and pending matrices, column-major
    logic signed [ELEM_W-1:0] accum_m   [DIM*DIM];
    logic signed [ELEM_W-1:0] pending_m [DIM*DIM];

    matrix4x4_chain_multiply_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // identity in the fixed point format, pending matrix cleared
    function automatic void reset_matrices();
        for (int i = 0; i < DIM*DIM; i++)
        begin
            accum_m[i]   = (i % 5 == 0) ? FIX_ONE : '0;
            pending_m[i] = '0;
        end
    endfunction

    // row r of the accumulated matrix times the carried column:
    // exact sum of the four products, floor shift, then saturation
    function automatic logic [ELEM_W-1:0] dot_row(input item_t it, input int r);
        logic signed [ELEM_W-1:0] e [DIM];
        logic signed [SUM_W-1:0]  acc;
        logic signed [SUM_W-1:0]  sh;
        e[0] = it.elem0;
        e[1] = it.elem1;
        e[2] = it.elem2;
        e[3] = it.elem3;
        acc = '0;
        for (int k = 0; k < DIM; k++)
            acc = acc + accum_m[4*k + r] * e[k];
        // arithmetic shift rounds toward minus infinity
        sh = acc >>> FRAC_BITS;
        if (sh > MAX_Q)
            return MAX_Q;
        if (sh < MIN_Q)
            return MIN_Q;
        return sh[ELEM_W-1:0];
    endfunction

    // advance the shadow state by one transaction; returns 1 when a product column results
    function automatic bit matrix_step(input item_t it, output result_t res);
        logic [ELEM_W-1:0] d [DIM];
        int col;
        col = it.column;
        res = '0;
        if (it.command == CMD_LOAD)
        begin
            // a load changes the accumulated matrix at once, even mid-pass
            accum_m[4*col + 0] = it.elem0;
            accum_m[4*col + 1] = it.elem1;
            accum_m[4*col + 2] = it.elem2;
            accum_m[4*col + 3] = it.elem3;
            return 1'b0;
        end
        for (int r = 0; r < DIM; r++)
            d[r] = dot_row(it, r);
        for (int r = 0; r < DIM; r++)
            pending_m[4*col + r] = d[r];
        res.prod0      = d[0];
        res.prod1      = d[1];
        res.prod2      = d[2];
        res.prod3      = d[3];
        res.out_column = it.column;
        res.last       = (it.column == LAST_COL);
        // commit copies the whole pending matrix, unwritten columns included;
        // the pending matrix itself is kept
        if (res.last)
            for (int i = 0; i < DIM*DIM; i++)
                accum_m[i] = pending_m[i];
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    task automatic flag_error(input string what, input result_t want, input result_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s: expected %h %h %h %h col %0d last %0d, got %h %h %h %h col %0d last %0d",
                     what, want.prod0, want.prod1, want.prod2, want.prod3, want.out_column,
                     want.last, got.prod0, got.prod1, got.prod2, got.prod3, got.out_column,
                     got.last);
    endtask

    // input and output transactions are both taken here, inputs first,
    // so prediction and checking never race each other
    always @(posedge clk)
    begin : scoreboard
        stim_row_t row;
        result_t   calc;
        result_t   want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                row = row_q.pop_front();
                if (matrix_step(item, calc))
                    product_q.push_back(row.known ? row.res : calc);
            end
            if (result_valid && result_ready)
            begin
                if (product_q.size() == 0)
                    flag_error("unexpected result", '0, result);
                else
                begin
                    want = product_q.pop_front();
                    if (result.prod0 !== want.prod0 || result.prod1 !== want.prod1 ||
                        result.prod2 !== want.prod2 || result.prod3 !== want.prod3 ||
                        result.out_column !== want.out_column || result.last !== want.last)
                        flag_error("mismatch", want, result);
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // random stalls, none while quiet, and one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_LEN;
            result_ready <= 1'b0;
        end
        else
            result_ready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    // ---------------------------------------------------------------- sender

    // offer one transaction, holding it until accepted
    task automatic send(input stim_row_t row);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        row_q.push_back(row);
        item       <= row.it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent_cnt++;
    endtask

    // mostly small values, some full-range words, some extremes
    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2:
                case ($urandom_range(0, 4))
                    0: return MAX_Q;
                    1: return MIN_Q;
                    2: return '0;
                    3: return '1;
                    default: return FIX_ONE;
                endcase
            default: return ELEM_W'($urandom_range(0, 2*SMALL_SPAN) - SMALL_SPAN);
        endcase
    endfunction

    function automatic item_t mk_item(input command_t cmd, input int col,
                                      input logic [ELEM_W-1:0] e0, input logic [ELEM_W-1:0] e1,
                                      input logic [ELEM_W-1:0] e2, input logic [ELEM_W-1:0] e3);
        item_t it;
        it.command = cmd;
        it.column  = COL_W'(col);
        it.elem0   = e0;
        it.elem1   = e1;
        it.elem2   = e2;
        it.elem3   = e3;
        return it;
    endfunction

    function automatic result_t mk_res(input logic [ELEM_W-1:0] p0, input logic [ELEM_W-1:0] p1,
                                       input logic [ELEM_W-1:0] p2, input logic [ELEM_W-1:0] p3,
                                       input int col, input logic last);
        result_t r;
        r.prod0      = p0;
        r.prod1      = p1;
        r.prod2      = p2;
        r.prod3      = p3;
        r.out_column = COL_W'(col);
        r.last       = last;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input item_t it, input logic known, input result_t res);
        stim_row_t row;
        row.it    = it;
        row.known = known;
        row.res   = res;
        return row;
    endfunction

    task automatic send_rand(input command_t cmd, input int col);
        send(mk_row(mk_item(cmd, col, rand_elem(), rand_elem(), rand_elem(), rand_elem()),
                    1'b0, '0));
    endtask

    // a well-formed pass: a few loads, then multiplies in column order,
    // now and then a column skipped or a load slipped in between
    task automatic random_pass();
        int n_loads;
        n_loads = $urandom_range(0, 4);
        repeat (n_loads)
            send_rand(CMD_LOAD, $urandom_range(0, 3));
        for (int c = 0; c < DIM; c++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_rand(CMD_LOAD, $urandom_range(0, 3));
            if ($urandom_range(0, 7) != 0)
                send_rand(CMD_MULTIPLY, c);
        end
    endtask

    // directed rows; results typed in only where they follow at a glance
    function automatic void build_table();
        // commit right after reset: identity times the column, unwritten pending
        // columns are still zero so the accumulated matrix keeps only column 3
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 3, 1, 2, 3, 4), 1'b1,
                                 mk_res(1, 2, 3, 4, 3, 1'b1)));
        // only column 3 is nonzero now: -1 lsb times small values floors to -1
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 0, MAX_Q, MIN_Q, 0, '1), 1'b1,
                                 mk_res('1, '1, '1, '1, 0, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 1, FIX_ONE, -FIX_ONE, 1, 32'h00012345),
                                 1'b0, '0));
        // all-max matrix saturates both ways
        for (int c = 0; c < DIM; c++)
            dir_tab.push_back(mk_row(mk_item(CMD_LOAD, c, MAX_Q, MAX_Q, MAX_Q, MAX_Q), 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 0, MAX_Q, MAX_Q, MAX_Q, MAX_Q), 1'b1,
                                 mk_res(MAX_Q, MAX_Q, MAX_Q, MAX_Q, 0, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 1, MIN_Q, MIN_Q, MIN_Q, MIN_Q), 1'b1,
                                 mk_res(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 1, 1'b0)));
        // load in the middle of a pass takes effect for the next column
        dir_tab.push_back(mk_row(mk_item(CMD_LOAD, 2, MIN_Q, MIN_Q, MIN_Q, MIN_Q), 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 2, MIN_Q, MIN_Q, MIN_Q, MIN_Q), 1'b1,
                                 mk_res(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 2, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 3, 0, 0, 0, 0), 1'b1,
                                 mk_res(0, 0, 0, 0, 3, 1'b1)));
        // lone column 3 commit: columns 0..2 come from the previous pass
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 3, FIX_ONE, 32'h00008000, '1, 7),
                                 1'b0, '0));
        // rounding toward minus infinity: 0.5 times -1 lsb gives -1, times +1 lsb gives 0
        dir_tab.push_back(mk_row(mk_item(CMD_LOAD, 0, 32'h00008000, 0, 0, 0), 1'b0, '0));
        for (int c = 1; c < DIM; c++)
            dir_tab.push_back(mk_row(mk_item(CMD_LOAD, c, 0, 0, 0, 0), 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 0, '1, 0, 0, 0), 1'b1,
                                 mk_res('1, 0, 0, 0, 0, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 1, 1, 0, 0, 0), 1'b1,
                                 mk_res(0, 0, 0, 0, 1, 1'b0)));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 2, MAX_Q, 32'h12345678, MIN_Q, FIX_ONE),
                                 1'b0, '0));
        dir_tab.push_back(mk_row(mk_item(CMD_MULTIPLY, 3, 32'hFFFF8000, FIX_ONE, 3, MAX_Q),
                                 1'b0, '0));
    endfunction

    // ---------------------------------------------------------------- main flow

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        quiet        = 1'b0;
        hold_go      = 1'b0;
        reset_matrices();
        build_table();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows with random idling on both sides
        foreach (dir_tab[i])
            send(dir_tab[i]);

        // random part: a stretch with no idling first, then idling and the hold-off
        quiet <= 1'b1;
        while (sent_cnt < ITEMS)
        begin
            if (sent_cnt >= 180)
                quiet <= 1'b0;
            if (sent_cnt >= 260)
                hold_go <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_rand(command_t'($urandom_range(0, 1)), $urandom_range(0, 3));
            else
                random_pass();
        end
        item_valid <= 1'b0;
        // let the scoreboard take the last input transaction first
        @(posedge clk);

        // drain, then watch for stray results
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (err_cnt == 0 && product_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
